FILE: design/tcce_pkg.sv
// shared types, constants and helper functions of the text console cursor engine
package tcce_pkg;

    localparam int LINE_BYTES     = 100;
    localparam int TEXT_ROWS      = 8;
    localparam int CELL_WIDTH     = 6;
    localparam int FONT_START     = 32;
    localparam int CELLS_PER_LINE = LINE_BYTES / CELL_WIDTH;

    localparam int COL_W    = 4;
    localparam int ROW_W    = 3;
    localparam int OFFSET_W = 7;
    localparam int GLYPH_W  = 8;
    localparam int CHAR_W   = 8;
    localparam int NUM_W    = 32;
    localparam int CMD_W    = 3;
    localparam int DIGIT_W  = 4;
    localparam int MAX_DIGITS = 10;
    localparam int COUNT_W  = 4;
    localparam int IDX_W    = $clog2(MAX_DIGITS);

    // floor(v / 10) == (v * RECIP_TEN) >> RECIP_SHIFT for every 32-bit v
    localparam logic [NUM_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int RECIP_SHIFT = 35;

    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
    localparam logic [CHAR_W-1:0] MINUS_CHAR   = 8'd45;

    localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
        8'd48, 8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55,
        8'd56, 8'd57, 8'd65, 8'd66, 8'd67, 8'd68, 8'd69, 8'd70
    };

    typedef enum logic [CMD_W-1:0] {
        CMD_CHAR    = 3'd0,
        CMD_ENDLINE = 3'd1,
        CMD_HEX     = 3'd2,
        CMD_UDEC    = 3'd3,
        CMD_SDEC    = 3'd4,
        CMD_SETPOS  = 3'd5
    } cmd_t;

    typedef struct packed {
        logic             put;
        logic             line_end;
        logic             set_pos;
        logic [COL_W-1:0] set_column;
        logic [ROW_W-1:0] set_row;
    } cursor_ctrl_t;

    typedef struct packed {
        logic [ROW_W-1:0]    row;
        logic [OFFSET_W-1:0] offset;
    } cursor_pos_t;

    typedef struct packed {
        logic load;
        logic hex;
        logic mul;
        logic step;
    } unit_ctrl_t;

    function automatic logic [GLYPH_W-1:0] glyph_of(input logic [CHAR_W-1:0] code);
        logic [GLYPH_W-1:0] g;
        if (code >= CHAR_W'(FONT_START)) begin
            g = GLYPH_W'(code - CHAR_W'(FONT_START));
        end else begin
            g = '0;
        end
        return g;
    endfunction

endpackage

FILE: design/tcce_digit_unit.sv
// shared digit extraction unit: decimal: reciprocal multiply and remainder; hex: shift
module tcce_digit_unit
    import tcce_pkg::*;
(
    input  logic               aclk,
    input  unit_ctrl_t         ctrl,
    input  logic [NUM_W-1:0]   load_value,
    output logic [DIGIT_W-1:0] digit,
    output logic               quot_zero
);

    logic [NUM_W-1:0]   val_reg;
    logic [2*NUM_W-1:0] prod_reg;
    logic               hex_reg;
    logic [NUM_W-1:0]   quot;
    logic [NUM_W-1:0]   quot_x10;

    always_comb begin
        if (hex_reg) begin
            quot = {4'b0, val_reg[NUM_W-1:4]};
        end else begin
            quot = NUM_W'(prod_reg[2*NUM_W-1:RECIP_SHIFT]);
        end
        quot_x10 = (quot << 3) + (quot << 1);
    end

    assign digit     = hex_reg ? val_reg[DIGIT_W-1:0] : DIGIT_W'(val_reg - quot_x10);
    assign quot_zero = (quot == '0);

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            val_reg <= load_value;
            hex_reg <= ctrl.hex;
        end else if (ctrl.step) begin
            val_reg <= quot;
        end
        if (ctrl.mul) begin
            prod_reg <= (2*NUM_W)'(val_reg) * (2*NUM_W)'(RECIP_TEN);
        end
    end

endmodule

FILE: design/tcce_cursor.sv
// cursor column, row and skip-linefeed state with wrap handling
module tcce_cursor
    import tcce_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  cursor_ctrl_t ctrl,
    output cursor_pos_t  pos
);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             skip_reg, skip_next;
    logic [ROW_W-1:0] row_adv;

    assign row_adv = (row_reg == ROW_W'(TEXT_ROWS - 1)) ? '0 : row_reg + 1'b1;

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        skip_next = skip_reg;
        if (ctrl.put) begin
            if (col_reg == COL_W'(CELLS_PER_LINE - 1)) begin
                col_next  = '0;
                row_next  = row_adv;
                skip_next = 1'b1;
            end else begin
                col_next  = col_reg + 1'b1;
                skip_next = 1'b0;
            end
        end else if (ctrl.line_end) begin
            if (skip_reg) begin
                skip_next = 1'b0;
            end else begin
                col_next = '0;
                row_next = row_adv;
            end
        end else if (ctrl.set_pos) begin
            col_next = ctrl.set_column;
            row_next = ctrl.set_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            skip_reg <= 1'b0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            skip_reg <= skip_next;
        end
    end

    assign pos.row    = row_reg;
    assign pos.offset = OFFSET_W'({3'b0, col_reg} * OFFSET_W'(CELL_WIDTH));

endmodule

FILE: design/text_console_cursor_engine_core.sv
// top level of the text console cursor engine: command sequencer, digit buffer, write register
// One request at a time. Line end, set cursor and unused commands finish in the accept
// cycle and produce no write. A plain character makes one write, which may wait on the
// write channel. A hex number extracts its digits (up to 8) in ST_DIG and then writes
// them; a decimal number passes each digit through ST_MUL and ST_DIG in the shared
// reciprocal-multiply divide-by-ten unit and then writes them (up to 10), after a
// leading minus sign if negative. The write register lets the next request be taken
// while the final write of the previous one is still waiting on m_tready.
module text_console_cursor_engine_core
    import tcce_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // char_code[7:0], number_value[39:8], set_column[43:40], set_row[46:44], zero pad
    input  logic [47:0] s_tdata,
    // command[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // text_row[2:0], byte_offset[9:3], glyph_index[17:10], zero pad
    output logic [23:0] m_tdata,
    output logic        m_tlast
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHAR  = 6'b000010,
        ST_SIGN  = 6'b000100,
        ST_MUL   = 6'b001000,
        ST_DIG   = 6'b010000,
        ST_PRINT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [CHAR_W-1:0]  in_char;
    logic [NUM_W-1:0]   in_num;
    logic [COL_W-1:0]   in_col;
    logic [ROW_W-1:0]   in_row;
    cmd_t               in_cmd;
    logic               accept;
    logic               in_neg;

    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               hex_reg, hex_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [DIGIT_W-1:0] digit_buf [MAX_DIGITS];
    logic [IDX_W-1:0]   rd_idx;

    logic               m_valid_reg, m_valid_next;
    logic               m_last_reg;
    logic [ROW_W-1:0]   m_row_reg;
    logic [OFFSET_W-1:0] m_off_reg;
    logic [GLYPH_W-1:0] m_glyph_reg;

    logic               out_free;
    logic               emit;
    logic               emit_last;
    logic [CHAR_W-1:0]  emit_char;

    cursor_ctrl_t       cur_ctrl;
    cursor_pos_t        cur_pos;
    unit_ctrl_t         unit_ctrl;
    logic [NUM_W-1:0]   unit_value;
    logic [DIGIT_W-1:0] unit_digit;
    logic               unit_qzero;

    assign in_char = s_tdata[7:0];
    assign in_num  = s_tdata[39:8];
    assign in_col  = s_tdata[43:40];
    assign in_row  = s_tdata[46:44];
    assign in_cmd  = cmd_t'(s_tuser);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_neg   = (in_cmd == CMD_SDEC) && in_num[NUM_W-1];

    assign out_free = !m_valid_reg || m_tready;
    assign rd_idx   = IDX_W'(count_reg - 1'b1);

    always_comb begin
        emit_char = char_reg;
        emit_last = 1'b1;
        emit      = 1'b0;
        unique case (state_reg)
            ST_CHAR: begin
                emit = out_free;
            end
            ST_SIGN: begin
                emit      = out_free;
                emit_char = MINUS_CHAR;
                emit_last = 1'b0;
            end
            ST_PRINT: begin
                emit      = out_free;
                emit_char = DIGIT_CHARS[digit_buf[rd_idx]];
                emit_last = (count_reg == COUNT_W'(1));
            end
            ST_IDLE, ST_MUL, ST_DIG: begin
                emit = 1'b0;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // cursor updates: writes, line ends and in-range position sets
    always_comb begin
        cur_ctrl.put        = emit;
        cur_ctrl.line_end   = accept && ((in_cmd == CMD_ENDLINE) ||
                              ((in_cmd == CMD_CHAR) && (in_char == NEWLINE_CHAR)));
        cur_ctrl.set_pos    = accept && (in_cmd == CMD_SETPOS) &&
                              (32'(in_col) < CELLS_PER_LINE) && (32'(in_row) < TEXT_ROWS);
        cur_ctrl.set_column = in_col;
        cur_ctrl.set_row    = in_row;
    end

    always_comb begin
        unit_ctrl.load = accept && ((in_cmd == CMD_HEX) || (in_cmd == CMD_UDEC) ||
                                    (in_cmd == CMD_SDEC));
        unit_ctrl.hex  = (in_cmd == CMD_HEX);
        unit_ctrl.mul  = (state_reg == ST_MUL);
        unit_ctrl.step = (state_reg == ST_DIG);
        unit_value     = in_neg ? (~in_num + 1'b1) : in_num;
    end

    always_comb begin
        state_next = state_reg;
        char_next  = char_reg;
        hex_next   = hex_reg;
        count_next = count_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_cmd) inside
                        CMD_CHAR: begin
                            if (in_char != NEWLINE_CHAR) begin
                                char_next  = in_char;
                                state_next = ST_CHAR;
                            end
                        end
                        CMD_HEX, CMD_UDEC, CMD_SDEC: begin
                            hex_next   = (in_cmd == CMD_HEX);
                            count_next = '0;
                            if (in_neg) begin
                                state_next = ST_SIGN;
                            end else if (in_cmd == CMD_HEX) begin
                                state_next = ST_DIG;
                            end else begin
                                state_next = ST_MUL;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CHAR: begin
                if (emit) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SIGN: begin
                if (emit) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_DIG;
            end
            ST_DIG: begin
                count_next = count_reg + 1'b1;
                if (unit_qzero || (count_reg == COUNT_W'(MAX_DIGITS - 1))) begin
                    state_next = ST_PRINT;
                end else if (hex_reg) begin
                    state_next = ST_DIG;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_PRINT: begin
                if (emit) begin
                    count_next = count_reg - 1'b1;
                    if (count_reg == COUNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg <= char_next;
        hex_reg  <= hex_next;
        if (state_reg == ST_DIG) begin
            digit_buf[IDX_W'(count_reg)] <= unit_digit;
        end
        if (emit) begin
            m_row_reg   <= cur_pos.row;
            m_off_reg   <= cur_pos.offset;
            m_glyph_reg <= glyph_of(emit_char);
            m_last_reg  <= emit_last;
        end
    end

    tcce_cursor u_cursor (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (cur_ctrl),
        .pos     (cur_pos)
    );

    tcce_digit_unit u_digit_unit (
        .aclk       (aclk),
        .ctrl       (unit_ctrl),
        .load_value (unit_value),
        .digit      (unit_digit),
        .quot_zero  (unit_qzero)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {6'b0, m_glyph_reg, m_off_reg, m_row_reg};

    // printing always has at least one buffered digit
    a_print_has_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PRINT) |-> (count_reg != '0))
        else $error("print state with empty digit buffer");

    // the digit count never passes the buffer depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg <= COUNT_W'(MAX_DIGITS)))
        else $error("digit count beyond buffer depth");

    // line end and set cursor requests leave the block ready in the next cycle
    a_no_write_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && ((in_cmd == CMD_ENDLINE) || (in_cmd == CMD_SETPOS))) |=> s_tready)
        else $error("non-writing request left the block busy");

    // the last digit written returns the sequencer to idle
    a_last_digit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_PRINT) && emit && (count_reg == COUNT_W'(1)))
            |=> (state_reg == ST_IDLE) && m_tvalid && m_tlast)
        else $error("final digit write did not end the request");

endmodule

FILE: dv/tb_text_console_cursor_engine_core.sv
// testbench of the text console cursor engine: request driver, glyph write predictor and checker
import tcce_pkg::*;

class cursor_scoreboard;

    typedef struct packed {
        logic [ROW_W-1:0]    row;
        logic [OFFSET_W-1:0] offset;
        logic [GLYPH_W-1:0]  glyph;
        logic                last;
    } glyph_write_t;

    localparam logic [CHAR_W-1:0] ZERO_CHAR  = 8'h30;
    localparam logic [CHAR_W-1:0] ALPHA_CHAR = 8'h41;
    localparam int                DEC_BASE   = 10;
    localparam int                HEX_BASE   = 16;

    bit [COL_W-1:0] col;
    bit [ROW_W-1:0] row;
    bit             skip_lf;
    glyph_write_t   writes_due[$];
    int             errors;

    function void advance_row();
        int next_row;
        next_row = row + 1;
        row = (next_row >= TEXT_ROWS) ? '0 : ROW_W'(next_row);
    endfunction

    function void end_line();
        if (skip_lf) begin
            skip_lf = 1'b0;
        end else begin
            col = '0;
            advance_row();
        end
    endfunction

    function void emit_glyph(logic [CHAR_W-1:0] code);
        glyph_write_t w;
        int next_col;
        w.row    = row;
        w.offset = OFFSET_W'(col * CELL_WIDTH);
        w.glyph  = (code >= FONT_START) ? GLYPH_W'(code - FONT_START) : '0;
        w.last   = 1'b0;
        writes_due.push_back(w);
        next_col = col + 1;
        if (next_col >= CELLS_PER_LINE) begin
            // wrap at the right edge swallows the next line end
            col = '0;
            advance_row();
            skip_lf = 1'b1;
        end else begin
            col = COL_W'(next_col);
            skip_lf = 1'b0;
        end
    endfunction

    function void emit_number(bit [NUM_W-1:0] v, int base);
        int digits[MAX_DIGITS];
        int n;
        n = 0;
        do begin
            digits[n] = v % base;
            v = v / base;
            n++;
        end while (v != 0 && n < MAX_DIGITS);
        for (int i = n - 1; i >= 0; i--) begin
            if (digits[i] < DEC_BASE) begin
                emit_glyph(ZERO_CHAR + CHAR_W'(digits[i]));
            end else begin
                emit_glyph(ALPHA_CHAR + CHAR_W'(digits[i] - DEC_BASE));
            end
        end
    endfunction

    // predict the glyph writes of one accepted request
    function void note_request(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] code,
                               logic [NUM_W-1:0] value, logic [COL_W-1:0] set_col,
                               logic [ROW_W-1:0] set_row);
        int first;
        glyph_write_t w;
        first = writes_due.size();
        case (cmd)
            CMD_CHAR: begin
                if (code == NEWLINE_CHAR) begin
                    end_line();
                end else begin
                    emit_glyph(code);
                end
            end
            CMD_ENDLINE: end_line();
            CMD_HEX:     emit_number(value, HEX_BASE);
            CMD_UDEC:    emit_number(value, DEC_BASE);
            CMD_SDEC: begin
                if (value[NUM_W-1]) begin
                    emit_glyph(MINUS_CHAR);
                    value = ~value + 1'b1;
                end
                emit_number(value, DEC_BASE);
            end
            CMD_SETPOS: begin
                if (set_col < CELLS_PER_LINE && set_row < TEXT_ROWS) begin
                    col = set_col;
                    row = set_row;
                end
            end
            default: ;
        endcase
        if (writes_due.size() > first) begin
            w = writes_due.pop_back();
            w.last = 1'b1;
            writes_due.push_back(w);
        end
    endfunction

    function void check_write(logic [ROW_W-1:0] got_row, logic [OFFSET_W-1:0] got_offset,
                              logic [GLYPH_W-1:0] got_glyph, logic got_last);
        glyph_write_t want;
        if (writes_due.size() == 0) begin
            $display("%0t: unexpected write: expected none, actual row %0d offset %0d glyph %0d last %0b",
                     $time, got_row, got_offset, got_glyph, got_last);
            errors++;
            return;
        end
        want = writes_due.pop_front();
        if (got_row !== want.row) begin
            $display("%0t: text_row expected %0d actual %0d", $time, want.row, got_row);
            errors++;
        end
        if (got_offset !== want.offset) begin
            $display("%0t: byte_offset expected %0d actual %0d", $time, want.offset, got_offset);
            errors++;
        end
        if (got_glyph !== want.glyph) begin
            $display("%0t: glyph_index expected %0d actual %0d", $time, want.glyph, got_glyph);
            errors++;
        end
        if (got_last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, got_last);
            errors++;
        end
    endfunction

    function bit busy();
        return writes_due.size() != 0;
    endfunction

endclass

module tb_text_console_cursor_engine_core;

    localparam int                RANDOM_REQUESTS = 500;
    localparam int                HOLD_CYCLES     = 300;
    localparam int                STALL_LIMIT     = 2000;
    localparam int                TAIL_CYCLES     = 40;
    localparam logic [CMD_W-1:0]  CMD_SPARE_A     = 3'd6;
    localparam logic [CMD_W-1:0]  CMD_SPARE_B     = 3'd7;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    cursor_scoreboard board = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req      = 1'b0;
    int hold_left     = 0;
    int stalled_cycles = 0;

    text_console_cursor_engine_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // write channel back pressure, with a single long hold-off
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_write(m_tdata[2:0], m_tdata[9:3], m_tdata[17:10], m_tlast);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
        if (stalled_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_request(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] code,
                                logic [NUM_W-1:0] value, logic [COL_W-1:0] column,
                                logic [ROW_W-1:0] row);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, row, column, value, code};
        do @(posedge aclk); while (!s_tready);
        board.note_request(cmd, code, value, column, row);
    endtask

    task automatic drain_writes();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (board.busy());
    endtask

    initial begin
        logic [CMD_W-1:0]  cmd;
        logic [CHAR_W-1:0] code;
        logic [NUM_W-1:0]  value;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        int                pick;
        int                printed;
        bit                hold_done;

        printed   = 0;
        hold_done = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: glyph range, every command, wraps and swallowed line end
        send_request(CMD_CHAR, 8'd65, '0, '0, '0);
        send_request(CMD_CHAR, 8'd0, '1, '1, '1);
        send_request(CMD_CHAR, 8'd31, '0, '0, '0);
        send_request(CMD_CHAR, 8'd32, '0, '0, '0);
        send_request(CMD_CHAR, 8'd255, '0, '0, '0);
        send_request(CMD_CHAR, NEWLINE_CHAR, '0, '0, '0);
        send_request(CMD_ENDLINE, '1, '1, '1, '1);
        send_request(CMD_HEX, '0, 32'h0, '0, '0);
        send_request(CMD_HEX, '0, 32'hFFFF_FFFF, '0, '0);
        send_request(CMD_UDEC, '0, 32'h0, '0, '0);
        send_request(CMD_UDEC, '0, 32'hFFFF_FFFF, '0, '0);
        send_request(CMD_SDEC, '0, 32'h8000_0000, '0, '0);
        send_request(CMD_SDEC, '0, 32'hFFFF_FFFF, '0, '0);
        send_request(CMD_SDEC, '0, 32'h7FFF_FFFF, '0, '0);
        send_request(CMD_SDEC, '0, 32'h0, '0, '0);
        send_request(CMD_SETPOS, '0, '0, 4'd15, 3'd7);
        send_request(CMD_CHAR, 8'd90, '0, '0, '0);
        send_request(CMD_ENDLINE, '0, '0, '0, '0);
        send_request(CMD_ENDLINE, '0, '0, '0, '0);
        send_request(CMD_SETPOS, '0, '0, 4'd13, 3'd5);
        send_request(CMD_UDEC, '0, 32'd123, '0, '0);
        send_request(CMD_CHAR, NEWLINE_CHAR, '0, '0, '0);
        send_request(CMD_SPARE_A, '1, '1, '1, '1);
        send_request(CMD_SPARE_B, 8'd66, 32'd7, 4'd3, 3'd2);
        send_request(CMD_SETPOS, '0, '0, 4'd0, 3'd0);
        drain_writes();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 47 : 0;
            recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 13 : 0;
            while (printed < RANDOM_REQUESTS * (phase + 1) / 3) begin
                pick   = $urandom_range(99);
                code   = CHAR_W'($urandom_range(255));
                column = COL_W'($urandom_range(15));
                row    = ROW_W'($urandom_range(7));
                case ($urandom_range(3))
                    0:       value = $urandom;
                    1:       value = $urandom >> $urandom_range(31);
                    2:       value = 32'd0 - ($urandom >> $urandom_range(31));
                    default: value = NUM_W'($urandom_range(9));
                endcase
                if (pick < 30) begin
                    cmd = CMD_CHAR;
                    if ($urandom_range(9) == 0) begin
                        code = NEWLINE_CHAR;
                    end
                end else if (pick < 40) begin
                    cmd = CMD_ENDLINE;
                end else if (pick < 52) begin
                    cmd = CMD_HEX;
                end else if (pick < 64) begin
                    cmd = CMD_UDEC;
                end else if (pick < 76) begin
                    cmd = CMD_SDEC;
                end else if (pick < 95) begin
                    cmd = CMD_SETPOS;
                    // land near the right edge often so wraps happen
                    if ($urandom_range(1) == 0) begin
                        column = COL_W'($urandom_range(15, 12));
                    end
                end else begin
                    cmd = ($urandom_range(1) == 0) ? CMD_SPARE_A : CMD_SPARE_B;
                end
                if (phase == 0 && !hold_done && printed >= RANDOM_REQUESTS / 6) begin
                    hold_req  = 1'b1;
                    hold_done = 1'b1;
                end
                send_request(cmd, code, value, column, row);
                if (cmd != CMD_SPARE_A && cmd != CMD_SPARE_B) begin
                    printed++;
                end
            end
            drain_writes();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (board.errors == 0 && !board.busy()) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            if (board.busy()) begin
                $display("%0t: %0d writes expected but never seen", $time,
                         board.writes_due.size());
            end
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: files.f
design/tcce_pkg.sv
design/tcce_digit_unit.sv
design/tcce_cursor.sv
design/text_console_cursor_engine_core.sv
dv/tb_text_console_cursor_engine_core.sv
